// File: rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants for the multimeter reading converter.
// ----------------------------------------------------------------------------
package mrc_pkg;

    // Widths sized for the widest supported ADC (16 bits)
    localparam int CODE_W  = 16;   // extended ADC code
    localparam int DIFF_W  = 17;   // signed code difference
    localparam int MAG_W   = 43;   // numerator magnitude
    localparam int K_W     = 34;   // scale factor (register, times 1000 for RES and CUR)
    localparam int DEN_W   = 43;   // denominator magnitude
    localparam int NUM_W   = 77;   // full numerator product
    localparam int QBITS   = 47;   // quotient bits below saturation
    localparam int SH_W    = DEN_W + QBITS;
    localparam int READ_W  = 48;
    localparam int TEMP_W  = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QDEPTH  = 4;

    localparam logic [QBITS-1:0] Q_MAX = {QBITS{1'b1}};

    // Measurement modes
    localparam logic [2:0] MODE_TEMP = 3'd1;
    localparam logic [2:0] MODE_VOLT = 3'd2;
    localparam logic [2:0] MODE_CAP  = 3'd3;
    localparam logic [2:0] MODE_RES  = 3'd4;
    localparam logic [2:0] MODE_CUR  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REF_UV  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R_BOT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R_REF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R_SHUNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_PF  = 3'd6;

    typedef struct packed {
        logic [23:0] ref_uv;
        logic [15:0] full_code;
        logic [23:0] r_top;
        logic [23:0] r_bot;
        logic [23:0] r_ref;
        logic [23:0] r_shunt;
        logic [31:0] cap_pf;
    } cfg_t;

    // One division job handed from front to back
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             fault;
        logic [2:0]       mode;
    } job_t;

endpackage

// File: rtl/multimeter_reading_converter.sv
// ----------------------------------------------------------------------------
// multimeter_reading_converter
// Converts a mode and two ADC codes into a saturated fixed-point reading.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, adc_a, adc_b and
//   temperature_in. Output channel (out_valid/out_ready) carries reading,
//   mode_echo, divide_fault and saturated, one result per input in order.
//   Configuration channel (cfg_valid/cfg_ready) writes register cfg_index
//   with cfg_data; cfg_ready is always high. Write only while idle.
//   Throughput: one item per cycle while the receiver does not stall. An
//   input passes through the five-stage front, one queue slot and the
//   47-stage bit-per-stage divider plus its load and output stages.
//   Reset clears all pipeline valid bits and the queue, and loads the
//   configuration registers with their defaults.
//   When the receiver stalls, the back end holds; the front keeps
//   accepting until the four-entry queue fills, then drops in_ready.
// ----------------------------------------------------------------------------
module multimeter_reading_converter #(
    parameter int ADC_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          action,
    input  logic [ADC_BITS-1:0] adc_a,
    input  logic [ADC_BITS-1:0] adc_b,
    input  logic signed [17:0]  temperature_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [47:0]  reading,
    output logic [2:0]          mode_echo,
    output logic                divide_fault,
    output logic                saturated
);
    import mrc_pkg::*;

    cfg_t cfg_reg;
    job_t push_job, head;
    logic push, pop, q_full, q_nonempty;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_uv    <= 24'd3300000;
            cfg_reg.full_code <= 16'd4095;
            cfg_reg.r_top     <= 24'd10000;
            cfg_reg.r_bot     <= 24'd10000;
            cfg_reg.r_ref     <= 24'd10000;
            cfg_reg.r_shunt   <= 24'd10000;
            cfg_reg.cap_pf    <= 32'd10000000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_REF_UV:  cfg_reg.ref_uv    <= cfg_data[23:0];
                REG_FULL:    cfg_reg.full_code <= cfg_data[15:0];
                REG_R_TOP:   cfg_reg.r_top     <= cfg_data[23:0];
                REG_R_BOT:   cfg_reg.r_bot     <= cfg_data[23:0];
                REG_R_REF:   cfg_reg.r_ref     <= cfg_data[23:0];
                REG_R_SHUNT: cfg_reg.r_shunt   <= cfg_data[23:0];
                REG_CAP_PF:  cfg_reg.cap_pf    <= cfg_data;
                default:     cfg_reg           <= cfg_reg;
            endcase
        end
    end

    mrc_front #(
        .ADC_BITS(ADC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .adc_a          (adc_a),
        .adc_b          (adc_b),
        .temperature_in (temperature_in),
        .q_full         (q_full),
        .push           (push),
        .push_job       (push_job)
    );

    mrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    mrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .nonempty     (q_nonempty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .reading      (reading),
        .mode_echo    (mode_echo),
        .divide_fault (divide_fault),
        .saturated    (saturated)
    );

endmodule

// File: rtl/mrc_front.sv
// ----------------------------------------------------------------------------
// mrc_front
// Accepts samples, classifies the mode and builds numerator and denominator.
// ----------------------------------------------------------------------------
module mrc_front #(
    parameter int ADC_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrc_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    action,
    input  logic [ADC_BITS-1:0]           adc_a,
    input  logic [ADC_BITS-1:0]           adc_b,
    input  logic signed [17:0]            temperature_in,
    input  logic                          q_full,
    output logic                          push,
    output mrc_pkg::job_t                 push_job
);
    import mrc_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 1: operands
    logic [2:0]               mode1_reg;
    logic signed [DIFF_W-1:0] d1_reg;
    logic signed [TEMP_W-1:0] t1_reg;
    logic [CODE_W-1:0]        a16, b16;
    logic signed [DIFF_W-1:0] d_next;

    // Stage 2: products
    logic [2:0]               mode2_reg;
    logic signed [DIFF_W-1:0] d2_reg;
    logic signed [TEMP_W-1:0] t2_reg;
    logic [39:0]              dr2_reg, dr1_reg, drs_reg;
    logic signed [42:0]       ds_reg;
    logic [K_W-1:0]           k2_reg;
    logic [K_W-1:0]           k_next;
    logic [24:0]              s_sum;

    // Stage 3: magnitudes
    logic [2:0]               mode3_reg;
    logic [MAG_W-1:0]         mag3_reg;
    logic [K_W-1:0]           k3_reg;
    logic [DEN_W-1:0]         den3_reg;
    logic                     neg3_reg, fault3_reg;
    logic [MAG_W-1:0]         mag_next;
    logic [DEN_W-1:0]         den_next;
    logic                     neg_next, fault_next;
    logic signed [43:0]       num4, den4, abs_num4, abs_den4;
    logic signed [17:0]       den3s, abs_den3;
    logic signed [DIFF_W-1:0] abs_d;
    logic signed [TEMP_W-1:0] abs_t;

    // Stage 4: partial products
    logic [2:0]               mode4_reg;
    logic [38:0]              pp00_reg, pp01_reg;
    logic [37:0]              pp10_reg, pp11_reg;
    logic [DEN_W-1:0]         den4_reg;
    logic                     neg4_reg, fault4_reg;

    // Stage 5: job
    job_t                     job5_reg;

    assign adv      = !(v5_reg && q_full);
    assign in_ready = adv;
    assign push     = v5_reg && adv;
    assign push_job = job5_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Form the signed code difference
    assign a16    = CODE_W'(adc_a);
    assign b16    = CODE_W'(adc_b);
    assign d_next = $signed({1'b0, a16}) - $signed({1'b0, b16});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg <= action;
            d1_reg    <= d_next;
            t1_reg    <= temperature_in;
        end
    end

    // Select the scale factor by mode
    assign s_sum = 25'(cfg.r_top) + 25'(cfg.r_bot);

    always_comb
    begin
        case (mode1_reg)
            MODE_VOLT: k_next = K_W'(cfg.ref_uv);
            MODE_CAP:  k_next = K_W'(cfg.cap_pf);
            MODE_RES:  k_next = K_W'(cfg.r_ref) * K_W'(1000);
            MODE_CUR:  k_next = K_W'(cfg.ref_uv) * K_W'(1000);
            default:   k_next = K_W'(1);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode2_reg <= mode1_reg;
            d2_reg    <= d1_reg;
            t2_reg    <= t1_reg;
            dr2_reg   <= 40'(cfg.full_code) * 40'(cfg.r_bot);
            dr1_reg   <= 40'(cfg.full_code) * 40'(cfg.r_top);
            drs_reg   <= 40'(cfg.full_code) * 40'(cfg.r_shunt);
            ds_reg    <= 43'(d1_reg) * $signed({18'b0, s_sum});
            k2_reg    <= k_next;
        end
    end

    // Build magnitudes, sign and fault per mode
    assign num4     = $signed({4'b0, dr2_reg}) - 44'(ds_reg);
    assign den4     = 44'(ds_reg) + $signed({4'b0, dr1_reg});
    assign abs_num4 = num4[43] ? -num4 : num4;
    assign abs_den4 = den4[43] ? -den4 : den4;
    assign den3s    = $signed({2'b0, cfg.full_code}) - 18'(d2_reg);
    assign abs_den3 = den3s[17] ? -den3s : den3s;
    assign abs_d    = d2_reg[DIFF_W-1] ? -d2_reg : d2_reg;
    assign abs_t    = t2_reg[TEMP_W-1] ? -t2_reg : t2_reg;

    always_comb
    begin
        mag_next   = '0;
        den_next   = DEN_W'(1);
        neg_next   = 1'b0;
        fault_next = 1'b0;
        case (mode2_reg)
            MODE_TEMP:
            begin
                // The most negative temperature negates to itself; read it unsigned
                mag_next = MAG_W'($unsigned(abs_t));
                neg_next = t2_reg[TEMP_W-1];
            end
            MODE_VOLT:
            begin
                if (cfg.full_code == '0)
                    fault_next = 1'b1;
                else
                begin
                    mag_next = MAG_W'(abs_d);
                    den_next = DEN_W'(cfg.full_code);
                    neg_next = d2_reg[DIFF_W-1];
                end
            end
            MODE_CAP:
            begin
                if (cfg.full_code == '0 || cfg.ref_uv == '0 || den3s == '0)
                    fault_next = 1'b1;
                else
                begin
                    mag_next = MAG_W'(abs_d);
                    den_next = DEN_W'(abs_den3);
                    neg_next = d2_reg[DIFF_W-1] ^ den3s[17];
                end
            end
            MODE_RES:
            begin
                if (cfg.full_code == '0 || cfg.ref_uv == '0 || den4 == '0)
                    fault_next = 1'b1;
                else
                begin
                    mag_next = abs_num4[MAG_W-1:0];
                    den_next = abs_den4[DEN_W-1:0];
                    neg_next = num4[43] ^ den4[43];
                end
            end
            MODE_CUR:
            begin
                if (drs_reg == '0)
                    fault_next = 1'b1;
                else
                begin
                    mag_next = MAG_W'(abs_d);
                    den_next = DEN_W'(drs_reg);
                    neg_next = d2_reg[DIFF_W-1];
                end
            end
            default:
            begin
                mag_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode3_reg  <= mode2_reg;
            mag3_reg   <= mag_next;
            k3_reg     <= k2_reg;
            den3_reg   <= den_next;
            neg3_reg   <= neg_next;
            fault3_reg <= fault_next;
        end
    end

    // Split the numerator product into four partial products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode4_reg  <= mode3_reg;
            pp00_reg   <= 39'(mag3_reg[21:0]) * 39'(k3_reg[16:0]);
            pp01_reg   <= 39'(mag3_reg[21:0]) * 39'(k3_reg[33:17]);
            pp10_reg   <= 38'(mag3_reg[42:22]) * 38'(k3_reg[16:0]);
            pp11_reg   <= 38'(mag3_reg[42:22]) * 38'(k3_reg[33:17]);
            den4_reg   <= den3_reg;
            neg4_reg   <= neg3_reg;
            fault4_reg <= fault3_reg;
        end
    end

    // Sum partial products into the job
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            job5_reg.num   <= NUM_W'(pp00_reg) + (NUM_W'(pp01_reg) << 17)
                            + (NUM_W'(pp10_reg) << 22) + (NUM_W'(pp11_reg) << 39);
            job5_reg.den   <= den4_reg;
            job5_reg.neg   <= neg4_reg;
            job5_reg.fault <= fault4_reg;
            job5_reg.mode  <= mode4_reg;
        end
    end

endmodule

// File: rtl/mrc_queue.sv
// ----------------------------------------------------------------------------
// mrc_queue
// Short job queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module mrc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mrc_pkg::job_t push_job,
    input  logic          pop,
    output mrc_pkg::job_t head,
    output logic          full,
    output logic          nonempty
);
    import mrc_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    job_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign head     = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == (PTR_W + 1)'(QDEPTH));
    assign nonempty = (count_reg != '0);

    // Store incoming job
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/mrc_back.sv
// ----------------------------------------------------------------------------
// mrc_back
// Pipelined restoring divider with saturation and signed output register.
// ----------------------------------------------------------------------------
module mrc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrc_pkg::job_t        head,
    input  logic                 nonempty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [47:0]   reading,
    output logic [2:0]           mode_echo,
    output logic                 divide_fault,
    output logic                 saturated
);
    import mrc_pkg::*;

    localparam int NST = QBITS + 1;

    logic                 adv;
    logic                 v_reg     [NST];
    logic [NUM_W-1:0]     rem_reg   [NST];
    logic [DEN_W-1:0]     den_reg   [NST];
    logic [QBITS-1:0]     q_reg     [NST];
    logic                 neg_reg   [NST];
    logic                 fault_reg [NST];
    logic                 sat_reg   [NST];
    logic [2:0]           mode_reg  [NST];

    logic                 out_valid_reg;
    logic signed [47:0]   reading_reg;
    logic [2:0]           mode_out_reg;
    logic                 fault_out_reg, sat_out_reg;
    logic                 sat_load;
    logic [QBITS-1:0]     q_final;
    logic [READ_W-1:0]    q_ext;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && nonempty;

    // Detect quotients beyond range at load
    assign sat_load = SH_W'(head.num) >= {head.den, {QBITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= nonempty;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]   <= head.num;
            den_reg[0]   <= head.den;
            q_reg[0]     <= '0;
            neg_reg[0]   <= head.neg;
            fault_reg[0] <= head.fault;
            sat_reg[0]   <= sat_load;
            mode_reg[0]  <= head.mode;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < QBITS; j++)
    begin : g_div
        localparam int SH = QBITS - 1 - j;
        logic [SH_W-1:0]  shifted;
        logic             ge;
        logic [NUM_W-1:0] rem_next;

        assign shifted  = SH_W'(den_reg[j]) << SH;
        assign ge       = SH_W'(rem_reg[j]) >= shifted;
        assign rem_next = ge ? (rem_reg[j] - shifted[NUM_W-1:0]) : rem_reg[j];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (adv)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1]   <= rem_next;
                den_reg[j+1]   <= den_reg[j];
                q_reg[j+1]     <= {q_reg[j][QBITS-2:0], ge};
                neg_reg[j+1]   <= neg_reg[j];
                fault_reg[j+1] <= fault_reg[j];
                sat_reg[j+1]   <= sat_reg[j];
                mode_reg[j+1]  <= mode_reg[j];
            end
        end
    end

    // Clip and apply sign
    assign q_final = sat_reg[NST-1] ? Q_MAX : q_reg[NST-1];
    assign q_ext   = {1'b0, q_final};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            reading_reg   <= neg_reg[NST-1] ? -$signed(q_ext) : $signed(q_ext);
            mode_out_reg  <= mode_reg[NST-1];
            fault_out_reg <= fault_reg[NST-1];
            sat_out_reg   <= sat_reg[NST-1] && !fault_reg[NST-1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign reading      = reading_reg;
    assign mode_echo    = mode_out_reg;
    assign divide_fault = fault_out_reg;
    assign saturated    = sat_out_reg;

endmodule
